// ===== src/mandelbrot_escape_time_pixel_defines.svh =====
// Assertion macros shared by the escape-time pixel engine.
// Each macro expects clk and arst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication
`define MEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mep_pkg.sv =====
package mep_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RE_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IM_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned COORD_W    = 10;
	localparam int unsigned COUNT_W    = 16;

	// Reset values of the configuration registers
	localparam logic signed [31:0] RE_ORIGIN_RST  = -32'sd536870912;
	localparam logic signed [31:0] IM_ORIGIN_RST  = -32'sd536870912;
	localparam logic [27:0]        RE_STEP_RST    = 28'd1342177;
	localparam logic [27:0]        IM_STEP_RST    = 28'd1342177;
	localparam logic [15:0]        ITER_LIMIT_RST = 16'd500;

	typedef struct packed {
		logic signed [31:0] re_origin;
		logic signed [31:0] im_origin;
		logic [27:0]        re_step;
		logic [27:0]        im_step;
		logic [15:0]        iter_limit;
	} mep_cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic init;
		logic mul;
		logic update;
		logic load_out;
	} mep_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic escaped;
		logic at_limit;
	} mep_stat_t;

endpackage

// ===== src/mep_cfg.sv =====
module mep_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,
	output mep_pkg::mep_cfg_t                   cfg
);
	import mep_pkg::*;

	mep_cfg_t cfg_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.re_origin  <= RE_ORIGIN_RST;
			cfg_q.im_origin  <= IM_ORIGIN_RST;
			cfg_q.re_step    <= RE_STEP_RST;
			cfg_q.im_step    <= IM_STEP_RST;
			cfg_q.iter_limit <= ITER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RE_ORIGIN:  cfg_q.re_origin  <= $signed(cfg_data);
				REG_IM_ORIGIN:  cfg_q.im_origin  <= $signed(cfg_data);
				REG_RE_STEP:    cfg_q.re_step    <= cfg_data[27:0];
				REG_IM_STEP:    cfg_q.im_step    <= cfg_data[27:0];
				REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mep_ctrl.sv =====
`include "mandelbrot_escape_time_pixel_defines.svh"

module mep_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  mep_pkg::mep_stat_t st,
	output mep_pkg::mep_cmd_t  cmd
);
	import mep_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_COORD = 5'b00010,
		ST_UPD   = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   finish;
	logic   out_free;

	assign finish   = st.escaped || st.at_limit;
	assign out_free = !out_valid_q || !out_stall;

	// Sequence one pixel: coordinate, then alternate update and multiply until escape or limit, then retire
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_COORD;
			ST_COORD: state_d = ST_UPD;
			ST_UPD:   state_d = finish ? ST_DONE : ST_MUL;
			ST_MUL:   state_d = ST_UPD;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath commands
	always_comb begin
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.init     = (state_q == ST_COORD);
		cmd.mul      = (state_q == ST_MUL);
		cmd.update   = (state_q == ST_UPD) && !finish;
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	`MEP_ASSERT_NEXT(a_accept_to_coord, in_valid && !in_stall, state_q == ST_COORD, "accepted item did not start")
	`MEP_ASSERT_NEXT(a_finish_to_done, state_q == ST_UPD && finish, state_q == ST_DONE, "finished pixel not retired")
	`MEP_ASSERT_NEXT(a_continue_to_mul, state_q == ST_UPD && !finish, state_q == ST_MUL, "unfinished pixel stopped")
	`MEP_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state_q == ST_DONE), "result appeared without a finished pixel")

endmodule

// ===== src/mep_dp.sv =====
`include "mandelbrot_escape_time_pixel_defines.svh"

module mep_dp #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mep_pkg::mep_cfg_t                   cfg,
	input  mep_pkg::mep_cmd_t                   cmd,
	output mep_pkg::mep_stat_t                  st,
	input  logic [mep_pkg::COORD_W-1:0]         column,
	input  logic [mep_pkg::COORD_W-1:0]         row,
	output logic [mep_pkg::COUNT_W-1:0]         iterations,
	output logic                                reached_limit,
	output logic [7:0]                          red,
	output logic [7:0]                          green_blue
);
	import mep_pkg::*;

	localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(MAX_COLUMNS - 1);
	localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(MAX_ROWS - 1);

	// Clamp a 40-bit sum into the Q4.28 range
	function automatic logic signed [31:0] sat_q(input logic signed [39:0] v);
		logic hi_ok;
		hi_ok = (v[39:31] == 9'h000) || (v[39:31] == 9'h1FF);
		if (hi_ok)
			return v[31:0];
		else if (v[39])
			return 32'sh8000_0000;
		else
			return 32'sh7FFF_FFFF;
	endfunction

	logic [COORD_W-1:0]        col_q, row_q;
	logic signed [31:0]        cre_q, cim_q;
	logic signed [31:0]        zr_q, zi_q;
	logic signed [63:0]        rr_q, ii_q, ri_q;
	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        limit;
	logic [37:0]               re_off, im_off;
	logic signed [39:0]        cre_sum, cim_sum;
	logic signed [63:0]        diff;
	logic signed [39:0]        nr_sum, ni_sum;
	logic [63:0]               mag;

	assign limit = (cfg.iter_limit == '0) ? COUNT_W'(1) : cfg.iter_limit;

	// Capture the clamped pixel indexes
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			col_q <= (32'(column) >= 32'(MAX_COLUMNS)) ? COL_LAST : column;
			row_q <= (32'(row) >= 32'(MAX_ROWS)) ? ROW_LAST : row;
		end
	end

	// Map the pixel to c
	assign re_off  = 38'(col_q) * 38'(cfg.re_step);
	assign im_off  = 38'(row_q) * 38'(cfg.im_step);
	assign cre_sum = $signed({2'b00, re_off}) + 40'(cfg.re_origin);
	assign cim_sum = $signed({2'b00, im_off}) + 40'(cfg.im_origin);

	// New iterate from the registered products
	assign diff   = rr_q - ii_q;
	assign nr_sum = $signed({{4{diff[63]}}, diff[63:28]}) + 40'(cre_q);
	assign ni_sum = $signed({{3{ri_q[63]}}, ri_q[63:27]}) + 40'(cim_q);

	// Escape test on the exact squares of the current iterate
	assign mag         = rr_q + ii_q;
	assign st.escaped  = |mag[63:58];
	assign st.at_limit = (count_q >= limit);

	// Start from z = 0 with zero products, then update and multiply in turn
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			cre_q   <= sat_q(cre_sum);
			cim_q   <= sat_q(cim_sum);
			zr_q    <= '0;
			zi_q    <= '0;
			rr_q    <= '0;
			ii_q    <= '0;
			ri_q    <= '0;
			count_q <= '0;
		end else if (cmd.mul) begin
			rr_q <= zr_q * zr_q;
			ii_q <= zi_q * zi_q;
			ri_q <= zr_q * zi_q;
		end else if (cmd.update) begin
			zr_q    <= sat_q(nr_sum);
			zi_q    <= sat_q(ni_sum);
			count_q <= count_q + COUNT_W'(1);
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			iterations    <= count_q;
			reached_limit <= !st.escaped;
			red           <= count_q[7:0];
			green_blue    <= {count_q[4:0], 3'b000} - count_q[7:0];
		end
	end

	`MEP_ASSERT_NOW(a_mul_below_limit, cmd.mul, count_q <= limit, "multiply issued past the iteration limit")
	`MEP_ASSERT_NOW(a_escape_after_step, st.escaped, count_q != '0, "escape seen before the first iteration")
	`MEP_ASSERT_NEXT(a_limit_count, cmd.load_out, !reached_limit || iterations == $past(limit), "limit flag with short count")

endmodule

// ===== src/mandelbrot_escape_time_pixel.sv =====
// Escape-time pixel engine: one pixel at a time, iterating by alternate update and multiply steps.
// The reported iteration count runs from 1 to iter_limit; an iter_limit of 0 acts as 1.
// A new pixel is accepted only in idle, after the previous one has moved to the output register.
// A finished result waits in the output register while the next pixel is accepted.
// Reset (arst_n low, asynchronous): idle, no result pending, config registers take their defaults.
module mandelbrot_escape_time_pixel #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mep_pkg::COORD_W-1:0]         column,
	input  logic [mep_pkg::COORD_W-1:0]         row,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mep_pkg::COUNT_W-1:0]         iterations,
	output logic                                reached_limit,
	output logic [7:0]                          red,
	output logic [7:0]                          green_blue
);
	import mep_pkg::*;

	mep_cfg_t  cfg;
	mep_cmd_t  cmd;
	mep_stat_t st;

	mep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	mep_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.st            (st),
		.column        (column),
		.row           (row),
		.iterations    (iterations),
		.reached_limit (reached_limit),
		.red           (red),
		.green_blue    (green_blue)
	);

endmodule
